### sv/gxb_pkg.sv
// ----------------------------------------------------------------------------
// gxb_pkg
// shared types, codes and constants of the glyph expansion blitter
// ----------------------------------------------------------------------------
package gxb_pkg;

   localparam int FRAME_WIDTH         = 256;
   localparam int FRAME_ROWS_DEFAULT  = 192;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int ROW_W               = 11;
   localparam int CSR_ADDR_W          = 5;
   localparam int CSR_DATA_W          = 32;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      DEPTH_NONE = 2'd0,
      DEPTH_1    = 2'd1,
      DEPTH_2    = 2'd2,
      DEPTH_8    = 2'd3
   } depth_type;

   typedef enum logic [2:0] {
      REG_PALETTE_0   = 3'd0,
      REG_PALETTE_1   = 3'd1,
      REG_PALETTE_2   = 3'd2,
      REG_PALETTE_3   = 3'd3,
      REG_FONT_HEIGHT = 3'd4,
      REG_ZONE_LEFT   = 3'd5,
      REG_ZONE_TOP    = 3'd6,
      REG_ZONE_RIGHT  = 3'd7
   } reg_type;

   typedef struct packed {
      logic       command;
      logic [7:0] x_offset;
      logic [7:0] y_offset;
      logic [5:0] glyph_width_m1;
      logic [5:0] glyph_height_m1;
      logic [1:0] depth_mode;
      logic [7:0] data_byte;
   } gxb_req_type;

   typedef struct packed {
      logic [14:0] halfword_address;
      logic [15:0] write_data;
      logic [1:0]  byte_enable;
      logic        last_of_glyph;
   } gxb_rsp_type;

   typedef struct packed {
      logic [7:0] palette_0;
      logic [7:0] palette_1;
      logic [7:0] palette_2;
      logic [7:0] palette_3;
      logic [5:0] font_height;
      logic [7:0] zone_left;
      logic [7:0] zone_top;
      logic [8:0] zone_right;
   } gxb_cfg_type;

   typedef struct packed {
      logic             is_start;
      logic [8:0]       origin_column;
      logic [ROW_W-1:0] origin_row;
      logic [6:0]       draw_width;
      logic [5:0]       width_m1;
      logic [5:0]       height_m1;
      logic [1:0]       depth;
      logic [7:0]       data_byte;
   } gxb_entry_type;

endpackage

### sv/gxb_csr.sv
// ----------------------------------------------------------------------------
// gxb_csr
// apb register file: palette, font height and drawing zone
// ----------------------------------------------------------------------------
module gxb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gxb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gxb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [gxb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output gxb_pkg::gxb_cfg_type             cfg
);
   import gxb_pkg::*;

   gxb_cfg_type cfg_ff, cfg_in;
   reg_type     sel;
   logic        wr;

   assign sel    = reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (sel)
            REG_PALETTE_0:   cfg_in.palette_0   = pwdata[7:0];
            REG_PALETTE_1:   cfg_in.palette_1   = pwdata[7:0];
            REG_PALETTE_2:   cfg_in.palette_2   = pwdata[7:0];
            REG_PALETTE_3:   cfg_in.palette_3   = pwdata[7:0];
            REG_FONT_HEIGHT: cfg_in.font_height = pwdata[5:0];
            REG_ZONE_LEFT:   cfg_in.zone_left   = pwdata[7:0];
            REG_ZONE_TOP:    cfg_in.zone_top    = pwdata[7:0];
            REG_ZONE_RIGHT:  cfg_in.zone_right  = pwdata[8:0];
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (sel)
         REG_PALETTE_0:   prdata[7:0] = cfg_ff.palette_0;
         REG_PALETTE_1:   prdata[7:0] = cfg_ff.palette_1;
         REG_PALETTE_2:   prdata[7:0] = cfg_ff.palette_2;
         REG_PALETTE_3:   prdata[7:0] = cfg_ff.palette_3;
         REG_FONT_HEIGHT: prdata[5:0] = cfg_ff.font_height;
         REG_ZONE_LEFT:   prdata[7:0] = cfg_ff.zone_left;
         REG_ZONE_TOP:    prdata[7:0] = cfg_ff.zone_top;
         REG_ZONE_RIGHT:  prdata[8:0] = cfg_ff.zone_right;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.palette_0   <= 8'd0;
         cfg_ff.palette_1   <= 8'd255;
         cfg_ff.palette_2   <= 8'd255;
         cfg_ff.palette_3   <= 8'd255;
         cfg_ff.font_height <= 6'd11;
         cfg_ff.zone_left   <= 8'd0;
         cfg_ff.zone_top    <= 8'd0;
         cfg_ff.zone_right  <= 9'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/gxb_front.sv
// ----------------------------------------------------------------------------
// gxb_front
// accepts commands, works out glyph geometry for start commands
// ----------------------------------------------------------------------------
module gxb_front (
   input  gxb_pkg::gxb_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gxb_pkg::gxb_req_type   req_payload,
   input  logic                   queue_full,
   output logic                   push,
   output gxb_pkg::gxb_entry_type entry
);
   import gxb_pkg::*;

   logic [8:0]       x;
   logic [8:0]       right;
   logic [8:0]       span;
   logic [6:0]       width_p1;
   logic [6:0]       draw;
   logic [ROW_W-1:0] row;

   assign req_ready = ~queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      x        = {1'b0, cfg.zone_left} + {1'b0, req_payload.x_offset};
      right    = (cfg.zone_right > 9'(FRAME_WIDTH)) ? 9'(FRAME_WIDTH) : cfg.zone_right;
      span     = right - x;
      width_p1 = {1'b0, req_payload.glyph_width_m1} + 7'd1;
      if (x >= right) begin
         draw = 7'd0;
      end else if ({2'b00, width_p1} < span) begin
         draw = width_p1;
      end else begin
         draw = span[6:0];
      end
      row = ROW_W'(cfg.zone_top) + ROW_W'(req_payload.y_offset)
          + ROW_W'(cfg.font_height[5:1]) - ROW_W'(req_payload.glyph_height_m1[5:1]);

      entry.is_start      = (req_payload.command == CMD_START);
      entry.origin_column = x;
      entry.origin_row    = row;
      entry.draw_width    = draw;
      entry.width_m1      = req_payload.glyph_width_m1;
      entry.height_m1     = req_payload.glyph_height_m1;
      entry.depth         = req_payload.depth_mode;
      entry.data_byte     = req_payload.data_byte;
   end

endmodule

### sv/gxb_queue.sv
// ----------------------------------------------------------------------------
// gxb_queue
// short fifo between command front and pixel engine
// ----------------------------------------------------------------------------
module gxb_queue #(
   parameter int DEPTH = gxb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gxb_pkg::gxb_entry_type push_entry,
   input  logic                   pop,
   output gxb_pkg::gxb_entry_type pop_entry,
   output logic                   full,
   output logic                   empty
);
   import gxb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   gxb_entry_type    slots_ff [DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]   rd_ptr_ff, rd_ptr_in;

   assign empty     = (wr_ptr_ff == rd_ptr_ff);
   assign full      = (wr_ptr_ff[PTR_W] != rd_ptr_ff[PTR_W])
                    && (wr_ptr_ff[PTR_W-1:0] == rd_ptr_ff[PTR_W-1:0]);
   assign pop_entry = slots_ff[rd_ptr_ff[PTR_W-1:0]];
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff[PTR_W-1:0]] <= push_entry;
      end
   end

endmodule

### sv/gxb_back.sv
// ----------------------------------------------------------------------------
// gxb_back
// pixel engine: one pixel per cycle unless the write output stalls, pairs pixels into halfword writes
// ----------------------------------------------------------------------------
module gxb_back #(
   parameter int FRAME_ROWS = gxb_pkg::FRAME_ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gxb_pkg::gxb_cfg_type   cfg,
   input  logic                   entry_valid,
   input  gxb_pkg::gxb_entry_type entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gxb_pkg::gxb_rsp_type   rsp_payload
);
   import gxb_pkg::*;

   logic [8:0]       origin_col_ff, origin_col_in;
   logic [ROW_W-1:0] origin_row_ff, origin_row_in;
   logic [6:0]       draw_width_ff, draw_width_in;
   logic [5:0]       width_ff, width_in;
   logic [5:0]       height_ff, height_in;
   depth_type        depth_ff, depth_in;
   logic [6:0]       cur_row_ff, cur_row_in;
   logic [6:0]       cur_col_ff, cur_col_in;
   logic [7:0]       held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic             busy_ff, busy_in;
   logic [3:0]       pix_left_ff, pix_left_in;
   logic [7:0]       shift_ff, shift_in;
   logic             rsp_valid_ff, rsp_valid_in;
   gxb_rsp_type      rsp_ff, rsp_in;

   logic             adv;
   logic             step;
   logic [1:0]       code;
   logic [7:0]       color;
   logic [ROW_W-1:0] row_sum;
   logic             active;
   logic             in_frame;
   logic [7:0]       sx;
   logic             at_end;
   logic             held_use;
   logic             wr_now;
   gxb_rsp_type      wr;

   assign adv         = ~rsp_valid_ff | rsp_ready;
   assign step        = busy_ff & adv;
   assign pop         = entry_valid & (~busy_ff | (step & (pix_left_ff == 4'd1)));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      code = (depth_ff == DEPTH_2) ? shift_ff[7:6] : {1'b0, shift_ff[7]};
      unique case (code)
         2'd0: color = cfg.palette_0;
         2'd1: color = cfg.palette_1;
         2'd2: color = cfg.palette_2;
         2'd3: color = cfg.palette_3;
      endcase
      if (depth_ff == DEPTH_8) begin
         color = shift_ff;
      end
      row_sum  = origin_row_ff + ROW_W'(cur_row_ff);
      active   = (cur_row_ff <= {1'b0, height_ff});
      in_frame = active && (cur_col_ff < draw_width_ff) && !row_sum[ROW_W-1]
               && (row_sum < ROW_W'(FRAME_ROWS));
      sx       = origin_col_ff[7:0] + {1'b0, cur_col_ff};
      at_end   = (cur_col_ff + 7'd1 == draw_width_ff);
      held_use = held_valid_ff && (held_ff != 8'd0);

      wr.halfword_address = {row_sum[7:0], sx[7:1]};
      wr.last_of_glyph    = at_end && ((cur_row_ff == {1'b0, height_ff})
                          || (row_sum == ROW_W'(FRAME_ROWS - 1)));
      if (sx[0]) begin
         wr.write_data  = {color, held_use ? held_ff : 8'd0};
         wr.byte_enable = {color != 8'd0, held_use};
      end else begin
         wr.write_data  = {8'd0, color};
         wr.byte_enable = {1'b0, color != 8'd0};
      end
      wr_now = step && in_frame && (sx[0] || at_end);
   end

   always_comb begin
      origin_col_in = origin_col_ff;
      origin_row_in = origin_row_ff;
      draw_width_in = draw_width_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      depth_in      = depth_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      busy_in       = busy_ff;
      pix_left_in   = pix_left_ff;
      shift_in      = shift_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (adv) begin
         rsp_valid_in = wr_now;
         rsp_in       = wr;
      end

      if (step) begin
         if (in_frame) begin
            if (sx[0]) begin
               held_valid_in = 1'b0;
            end else if (!at_end) begin
               held_in       = color;
               held_valid_in = 1'b1;
            end
         end
         if (active) begin
            if (cur_col_ff >= {1'b0, width_ff}) begin
               cur_col_in    = 7'd0;
               cur_row_in    = cur_row_ff + 7'd1;
               held_valid_in = 1'b0;
            end else begin
               cur_col_in = cur_col_ff + 7'd1;
            end
         end
         shift_in    = (depth_ff == DEPTH_2) ? {shift_ff[5:0], 2'b00}
                                             : {shift_ff[6:0], 1'b0};
         pix_left_in = pix_left_ff - 4'd1;
         busy_in     = (pix_left_ff != 4'd1);
      end

      if (pop) begin
         if (entry.is_start) begin
            origin_col_in = entry.origin_column;
            origin_row_in = entry.origin_row;
            draw_width_in = entry.draw_width;
            width_in      = entry.width_m1;
            height_in     = entry.height_m1;
            depth_in      = depth_type'(entry.depth);
            cur_row_in    = 7'd0;
            cur_col_in    = 7'd0;
            held_in       = 8'd0;
            held_valid_in = 1'b0;
            busy_in       = 1'b0;
         end else begin
            shift_in = entry.data_byte;
            unique case (depth_ff)
               DEPTH_NONE: pix_left_in = 4'd0;
               DEPTH_1:    pix_left_in = 4'd8;
               DEPTH_2:    pix_left_in = 4'd4;
               DEPTH_8:    pix_left_in = 4'd1;
            endcase
            busy_in = (depth_ff != DEPTH_NONE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff <= '0;
         origin_row_ff <= '0;
         draw_width_ff <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         depth_ff      <= DEPTH_NONE;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
         pix_left_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         origin_col_ff <= origin_col_in;
         origin_row_ff <= origin_row_in;
         draw_width_ff <= draw_width_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         depth_ff      <= depth_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         busy_ff       <= busy_in;
         pix_left_ff   <= pix_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rsp_ff   <= rsp_in;
   end

endmodule

### sv/glyph_expand_blitter.sv
// ----------------------------------------------------------------------------
// glyph_expand_blitter
// path: a data byte goes through the queue slot, the shift register and the
//   write register, its first write coming from the first pixel closing a pair
// throughput: the pixel engine handles one pixel per cycle unless writes stall;
//   a byte holds 8 pixels at 1 bit, 4 at 2 bits, 1 at 8 bits
// reset: synchronous, restores register defaults and empties queue and engine
// ----------------------------------------------------------------------------
module glyph_expand_blitter #(
   parameter int FRAME_ROWS  = gxb_pkg::FRAME_ROWS_DEFAULT,
   parameter int QUEUE_DEPTH = gxb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gxb_pkg::gxb_req_type           req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gxb_pkg::gxb_rsp_type           rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gxb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gxb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gxb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import gxb_pkg::*;

   gxb_cfg_type   cfg;
   gxb_entry_type push_entry;
   gxb_entry_type pop_entry;
   logic          push;
   logic          pop;
   logic          full;
   logic          empty;

   gxb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gxb_front u_front (
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (full),
      .push        (push),
      .entry       (push_entry)
   );

   gxb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (full),
      .empty      (empty)
   );

   gxb_back #(
      .FRAME_ROWS (FRAME_ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .entry_valid (~empty),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### sv/gxb_checker.sv
// ----------------------------------------------------------------------------
// gxb_checker
// port level checks of the glyph expansion blitter, bound to the top level
// ----------------------------------------------------------------------------
module gxb_checker #(
   parameter int FRAME_ROWS = gxb_pkg::FRAME_ROWS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input gxb_pkg::gxb_rsp_type rsp_payload
);
   import gxb_pkg::*;

   // a stalled transfer holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // disabled bytes carry zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_enable[0] |-> rsp_payload.write_data[7:0] == 8'd0)
      else $error("low byte not zero while disabled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_enable[1] |-> rsp_payload.write_data[15:8] == 8'd0)
      else $error("high byte not zero while disabled");

   // writes stay inside the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_payload.halfword_address[14:7]} < 9'(FRAME_ROWS))
      else $error("write below the frame");

endmodule

bind glyph_expand_blitter gxb_checker #(
   .FRAME_ROWS (FRAME_ROWS)
) u_gxb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### dv/glyph_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_write_checker
// watches the request, write and register ports of the glyph blitter, keeps
// its own copy of the palette, zone and glyph state, works out the
// framebuffer writes that each accepted transfer implies, and compares every
// write the block emits against the oldest one still outstanding
// ----------------------------------------------------------------------------
module glyph_write_checker #(
   parameter int FRAME_ROWS = gxb_pkg::FRAME_ROWS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  gxb_pkg::gxb_req_type           req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  gxb_pkg::gxb_rsp_type           rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [gxb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gxb_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             mismatch_count,
   output int                             writes_pending
);
   import gxb_pkg::*;

   logic [7:0]  palette [4];
   logic [5:0]  font_height;
   logic [7:0]  zone_left;
   logic [7:0]  zone_top;
   logic [8:0]  zone_right;

   logic [8:0]  origin_column;
   int          origin_row;
   logic [6:0]  draw_width;
   logic [5:0]  glyph_width_m1;
   logic [5:0]  glyph_height_m1;
   depth_type   glyph_depth;
   logic [6:0]  cur_row;
   logic [6:0]  cur_column;
   logic [7:0]  held_pixel;
   logic        held_valid;

   gxb_rsp_type expected_writes [$];
   int          errors;

   task automatic place_pixel(input logic [7:0] colour);
      int          col;
      int          row;
      int          sx;
      logic        row_end;
      gxb_rsp_type w;
      col = int'(cur_column);
      row = origin_row + int'(cur_row);
      if (cur_row > glyph_height_m1) return;
      if (col < int'(draw_width) && row >= 0 && row < FRAME_ROWS) begin
         sx = int'(origin_column) + col;
         row_end = (col + 1 == int'(draw_width));
         w.halfword_address = 15'((row * FRAME_WIDTH + sx) >> 1);
         w.last_of_glyph = row_end && (cur_row == glyph_height_m1 || row == FRAME_ROWS - 1);
         if ((sx & 1) == 0) begin
            if (row_end) begin
               w.write_data  = {8'h00, colour};
               w.byte_enable = {1'b0, colour != 8'h00};
               expected_writes.push_back(w);
            end else begin
               held_pixel = colour;
               held_valid = 1'b1;
            end
         end else begin
            // left half comes from the pixel held at the even column
            if (held_valid && held_pixel != 8'h00) begin
               w.write_data  = {colour, held_pixel};
               w.byte_enable = {colour != 8'h00, 1'b1};
            end else begin
               w.write_data  = {colour, 8'h00};
               w.byte_enable = {colour != 8'h00, 1'b0};
            end
            expected_writes.push_back(w);
            held_valid = 1'b0;
         end
      end
      if (cur_column >= 7'(glyph_width_m1)) begin
         cur_column = '0;
         cur_row    = cur_row + 7'd1;
         held_valid = 1'b0;
      end else begin
         cur_column = cur_column + 7'd1;
      end
   endtask

   task automatic begin_glyph(input gxb_req_type p);
      int x;
      int right;
      int span;
      x     = int'(zone_left) + int'(p.x_offset);
      right = (int'(zone_right) < FRAME_WIDTH) ? int'(zone_right) : FRAME_WIDTH;
      span  = int'(p.glyph_width_m1) + 1;
      origin_column = 9'(x);
      origin_row = int'(zone_top) + int'(p.y_offset) + int'(font_height) / 2
                 - int'(p.glyph_height_m1) / 2;
      if (x >= right)
         draw_width = '0;
      else
         draw_width = 7'((span < right - x) ? span : right - x);
      glyph_width_m1  = p.glyph_width_m1;
      glyph_height_m1 = p.glyph_height_m1;
      glyph_depth     = depth_type'(p.depth_mode);
      cur_row    = '0;
      cur_column = '0;
      held_pixel = '0;
      held_valid = 1'b0;
   endtask

   task automatic expand_byte(input logic [7:0] b);
      int i;
      case (glyph_depth)
         DEPTH_1: begin
            for (i = 7; i >= 0; i--) place_pixel(palette[(b >> i) & 8'd1]);
         end
         DEPTH_2: begin
            for (i = 3; i >= 0; i--) place_pixel(palette[(b >> (2 * i)) & 8'd3]);
         end
         DEPTH_8: begin
            place_pixel(b);
         end
         default: begin
         end
      endcase
   endtask

   function automatic bit field_differs(input string name, input int want, input int got);
      if (want != got)
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      return want != got;
   endfunction

   always @(posedge clock) begin
      gxb_rsp_type want;
      if (reset) begin
         palette[0]  = 8'd0;
         palette[1]  = 8'd255;
         palette[2]  = 8'd255;
         palette[3]  = 8'd255;
         font_height = 6'd11;
         zone_left   = 8'd0;
         zone_top    = 8'd0;
         zone_right  = 9'd256;
         origin_column   = '0;
         origin_row      = 0;
         draw_width      = '0;
         glyph_width_m1  = '0;
         glyph_height_m1 = '0;
         glyph_depth     = DEPTH_NONE;
         cur_row    = '0;
         cur_column = '0;
         held_pixel = '0;
         held_valid = 1'b0;
         expected_writes.delete();
         errors = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_type'(paddr[4:2]))
               REG_PALETTE_0:   palette[0]  = pwdata[7:0];
               REG_PALETTE_1:   palette[1]  = pwdata[7:0];
               REG_PALETTE_2:   palette[2]  = pwdata[7:0];
               REG_PALETTE_3:   palette[3]  = pwdata[7:0];
               REG_FONT_HEIGHT: font_height = pwdata[5:0];
               REG_ZONE_LEFT:   zone_left   = pwdata[7:0];
               REG_ZONE_TOP:    zone_top    = pwdata[7:0];
               REG_ZONE_RIGHT:  zone_right  = pwdata[8:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $display("%0t ns: unexpected write, expected none, got %p",
                        $time, rsp_payload);
               errors++;
            end else begin
               want = expected_writes.pop_front();
               if (field_differs("halfword_address", want.halfword_address,
                                 rsp_payload.halfword_address)
                   | field_differs("write_data", want.write_data, rsp_payload.write_data)
                   | field_differs("byte_enable", want.byte_enable, rsp_payload.byte_enable)
                   | field_differs("last_of_glyph", want.last_of_glyph,
                                   rsp_payload.last_of_glyph))
                  errors++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_payload.command == CMD_START)
               begin_glyph(req_payload);
            else
               expand_byte(req_payload.data_byte);
         end
      end
      mismatch_count <= errors;
      writes_pending <= expected_writes.size();
   end

endmodule

### dv/glyph_expand_blitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_expand_blitter_test
// drives glyph start and data transfers through a series of palette and zone
// settings, first a directed set of edge cases, then random glyph streams
// with random stalls on both channels; the checker beside the block predicts
// and compares every framebuffer write
// ----------------------------------------------------------------------------
module glyph_expand_blitter_test;
   import gxb_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   gxb_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   gxb_rsp_type           rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int   mismatch_count;
   int   writes_pending;
   int   items_sent = 0;
   int   stall_left = 0;
   logic calm = 1'b0;

   always #6 clock = ~clock;

   glyph_expand_blitter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   glyph_write_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .writes_pending (writes_pending)
   );

   // write-side backpressure in short bursts
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic gxb_req_type random_payload();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[$bits(gxb_req_type)-1:0];
   endfunction

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom());
      endcase
   endfunction

   task automatic send_item(input gxb_req_type p);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_start(input logic [7:0] x, input logic [7:0] y, input logic [5:0] w,
                             input logic [5:0] h, input depth_type d);
      gxb_req_type p;
      p = random_payload();
      p.command         = CMD_START;
      p.x_offset        = x;
      p.y_offset        = y;
      p.glyph_width_m1  = w;
      p.glyph_height_m1 = h;
      p.depth_mode      = d;
      send_item(p);
   endtask

   task automatic send_byte(input logic [7:0] b);
      gxb_req_type p;
      p = random_payload();
      p.command   = CMD_DATA;
      p.data_byte = b;
      send_item(p);
   endtask

   // one glyph: start, then mostly the exact byte count, sometimes short or long
   task automatic send_glyph_run();
      int         shape;
      int         kind;
      int         per_byte;
      int         n_bytes;
      int         i;
      logic [7:0] x;
      logic [7:0] y;
      logic [5:0] w;
      logic [5:0] h;
      depth_type  d;
      shape = $urandom_range(0, 9);
      kind  = $urandom_range(0, 9);
      d     = depth_type'($urandom_range(0, 3));
      if (d == DEPTH_NONE) begin
         w = 6'($urandom_range(0, 63));
         h = 6'($urandom_range(0, 63));
      end else if (shape == 0) begin
         w = 6'($urandom_range(32, 63));
         h = 6'($urandom_range(0, 1));
         if (d == DEPTH_8) d = DEPTH_1;
      end else if (shape == 1) begin
         w = 6'($urandom_range(0, 1));
         h = 6'($urandom_range(32, 63));
         if (d == DEPTH_8) d = DEPTH_2;
      end else begin
         w = 6'($urandom_range(0, 7));
         h = 6'($urandom_range(0, 7));
      end
      case (d)
         DEPTH_1: per_byte = 8;
         DEPTH_2: per_byte = 4;
         DEPTH_8: per_byte = 1;
         default: per_byte = 0;
      endcase
      if (per_byte == 0)
         n_bytes = $urandom_range(0, 3);
      else
         n_bytes = ((int'(w) + 1) * (int'(h) + 1) + per_byte - 1) / per_byte;
      if (kind == 8 && n_bytes > 0)
         n_bytes = $urandom_range(0, n_bytes - 1);
      else if (kind == 9)
         n_bytes = n_bytes + $urandom_range(1, 3);
      x = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
      y = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(0, 191));
      send_start(x, y, w, h, d);
      for (i = 0; i < n_bytes; i++) send_byte(random_byte());
   endtask

   task automatic write_reg(input reg_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input gxb_cfg_type c);
      write_reg(REG_PALETTE_0, CSR_DATA_W'(c.palette_0));
      write_reg(REG_PALETTE_1, CSR_DATA_W'(c.palette_1));
      write_reg(REG_PALETTE_2, CSR_DATA_W'(c.palette_2));
      write_reg(REG_PALETTE_3, CSR_DATA_W'(c.palette_3));
      write_reg(REG_FONT_HEIGHT, CSR_DATA_W'(c.font_height));
      write_reg(REG_ZONE_LEFT, CSR_DATA_W'(c.zone_left));
      write_reg(REG_ZONE_TOP, CSR_DATA_W'(c.zone_top));
      write_reg(REG_ZONE_RIGHT, CSR_DATA_W'(c.zone_right));
   endtask

   function automatic gxb_cfg_type random_setting();
      gxb_cfg_type c;
      c.palette_0   = $urandom_range(0, 1) ? 8'h00 : 8'($urandom());
      c.palette_1   = 8'($urandom());
      c.palette_2   = 8'($urandom());
      c.palette_3   = 8'($urandom());
      c.font_height = 6'($urandom_range(0, 63));
      c.zone_left   = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 64));
      c.zone_top    = 8'($urandom_range(0, 191));
      case ($urandom_range(0, 3))
         0:       c.zone_right = 9'd256;
         1:       c.zone_right = 9'($urandom_range(257, 511));
         default: c.zone_right = 9'($urandom_range(64, 255));
      endcase
      return c;
   endfunction

   // drain the write stream, then let queued no-write bytes run out
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (writes_pending != 0);
      repeat (64) @(posedge clock);
   endtask

   initial begin
      int          ph;
      int          mark;
      int          run_length [8];
      gxb_cfg_type preset [3];
      preset[0] = '{8'h7F, 8'h01, 8'h80, 8'hFE, 6'd0, 8'd200, 8'd0, 9'd511};
      preset[1] = '{8'h00, 8'hC3, 8'h00, 8'h3C, 6'd63, 8'd0, 8'd191, 9'd256};
      preset[2] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 6'd32, 8'd255, 8'd100, 9'd0};
      run_length = '{50, 50, 15, 56, 56, 56, 56, 56};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // data before any glyph
      send_byte(8'hFF);
      // one-bit glyph, solid and transparent rows, then a surplus byte
      send_start(8'd0, 8'd0, 6'd7, 6'd1, DEPTH_1);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h5A);
      // two-bit glyph at an odd column with an even end column
      send_start(8'd1, 8'd20, 6'd5, 6'd2, DEPTH_2);
      send_byte(8'h1B);
      send_byte(8'hE4);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h6C);
      // raw pixels running past the bottom of the frame
      send_start(8'd3, 8'd185, 6'd0, 6'd3, DEPTH_8);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'hFF);
      // no depth
      send_start(8'd0, 8'd0, 6'd7, 6'd0, DEPTH_NONE);
      send_byte(8'hAA);
      // clipped at the right edge
      send_start(8'd250, 8'd50, 6'd15, 6'd0, DEPTH_1);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // a new start drops the held left pixel
      send_start(8'd10, 8'd60, 6'd7, 6'd0, DEPTH_8);
      send_byte(8'h42);
      send_start(8'd11, 8'd60, 6'd0, 6'd0, DEPTH_8);
      send_byte(8'h33);

      for (ph = 0; ph < 8; ph++) begin
         settle();
         apply_setting((ph < 3) ? preset[ph] : random_setting());
         if (ph == 7) calm <= 1'b1;
         mark = items_sent;
         while (items_sent - mark < run_length[ph]) send_glyph_run();
      end
      settle();
      if (writes_pending != 0)
         $display("%0d expected writes never arrived", writes_pending);
      if (mismatch_count == 0 && writes_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_400_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
sv/gxb_pkg.sv
sv/gxb_csr.sv
sv/gxb_front.sv
sv/gxb_queue.sv
sv/gxb_back.sv
sv/glyph_expand_blitter.sv
sv/gxb_checker.sv
dv/glyph_write_checker.sv
dv/glyph_expand_blitter_test.sv
